// ===== rtl/plst_pkg.sv =====
// Shared types and codes for the positional list store.
// Holds operation and status codes and the controller-to-datapath command.
// No dependencies.
`timescale 1ns / 1ps

package plst_pkg;

    localparam logic [2:0] OP_ADD_FRONT  = 3'd0;
    localparam logic [2:0] OP_ADD_REAR   = 3'd1;
    localparam logic [2:0] OP_REM_FRONT  = 3'd2;
    localparam logic [2:0] OP_REM_REAR   = 3'd3;
    localparam logic [2:0] OP_REM_AT     = 3'd4;
    localparam logic [2:0] OP_INS_BEFORE = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic        load;
        logic [2:0]  op;
        logic [7:0]  position;
        logic [31:0] value;
    } t_cmd;

endpackage

// ===== rtl/positional_list_store.sv =====
// Positional list store: ordered list with front/rear and positioned insert/remove.
// The result is registered and is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the result is not stalled; every shift is done in one step by the cell row.
// Reset clears the entry count and the result valid; entries are left as they are.
// Depends on plst_pkg, plst_ctrl and plst_dp.
`timescale 1ns / 1ps

module positional_list_store #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_op,
    input  logic [7:0]         i_position,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_removed_value,
    output logic [4:0]         o_count
);

    plst_pkg::t_cmd w_cmd;

    plst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_op       (i_op),
        .i_position (i_position),
        .i_value    (i_value),
        .i_stall    (i_stall),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_cmd      (w_cmd)
    );

    plst_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_count         (o_count)
    );

endmodule

// ===== rtl/plst_ctrl.sv =====
// Handshake controller for the positional list store.
// Issues one load command per accepted request and holds the result valid.
// Depends on plst_pkg.
`timescale 1ns / 1ps

module plst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [2:0]         i_op,
    input  logic [7:0]         i_position,
    input  logic [31:0]        i_value,
    input  logic               i_stall,
    output logic               o_stall,
    output logic               o_valid,
    output plst_pkg::t_cmd     o_cmd
);

    typedef enum logic {S_EMPTY, S_HOLD} t_state;

    t_state r_state;
    t_state n_state;
    logic   w_load;

    assign o_stall = (r_state == S_HOLD) && i_stall;
    assign w_load  = i_valid && !o_stall;
    assign o_valid = (r_state == S_HOLD);

    assign o_cmd.load     = w_load;
    assign o_cmd.op       = i_op;
    assign o_cmd.position = i_position;
    assign o_cmd.value    = i_value;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_EMPTY: begin
                if (w_load) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (!i_stall && !w_load) n_state = S_EMPTY;
            end
            default: n_state = S_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && i_stall) |=> (r_state == S_HOLD))
        else $error("result dropped while stalled");
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state == S_HOLD))
        else $error("accepted request produced no result");
    a_no_load_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD && i_stall) |-> !w_load)
        else $error("request accepted over a stalled result");

endmodule

// ===== rtl/plst_dp.sv =====
// Datapath for the positional list store: a row of shifting cells,
// the entry count and the result registers.
// Depends on plst_pkg.
`timescale 1ns / 1ps

module plst_dp #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plst_pkg::t_cmd     i_cmd,
    output logic [1:0]         o_status,
    output logic [31:0]        o_removed_value,
    output logic [4:0]         o_count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int W  = (CW + 1 > 9) ? CW + 1 : 9;
    localparam logic [W-1:0] CAP_W = W'(CAPACITY);

    logic [VALUE_BITS-1:0] r_entries [CAPACITY];
    logic [VALUE_BITS-1:0] n_entries [CAPACITY];
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [1:0]            r_status;
    logic [1:0]            n_status;
    logic [VALUE_BITS-1:0] r_removed;
    logic [VALUE_BITS-1:0] n_removed;

    logic [W-1:0]          w_count;
    logic [W-1:0]          w_pos;
    logic [W-1:0]          w_idx;
    logic [IW-1:0]         w_sel;
    logic                  w_ins;
    logic                  w_rem;
    logic                  w_full;
    logic [VALUE_BITS-1:0] w_value;

    assign w_count = W'(r_count);
    assign w_pos   = W'(i_cmd.position);
    assign w_full  = (w_count >= CAP_W);
    assign w_value = VALUE_BITS'($unsigned(i_cmd.value));
    assign w_sel   = w_idx[IW-1:0];

    always_comb begin
        w_ins    = 1'b0;
        w_rem    = 1'b0;
        w_idx    = '0;
        n_status = plst_pkg::ST_OK;
        case (i_cmd.op)
            plst_pkg::OP_ADD_FRONT: begin
                if (w_full) n_status = plst_pkg::ST_FULL;
                else w_ins = 1'b1;
            end
            plst_pkg::OP_ADD_REAR: begin
                w_idx = w_count;
                if (w_full) n_status = plst_pkg::ST_FULL;
                else w_ins = 1'b1;
            end
            plst_pkg::OP_REM_FRONT: begin
                if (w_count == '0) n_status = plst_pkg::ST_UNDERFLOW;
                else w_rem = 1'b1;
            end
            plst_pkg::OP_REM_REAR: begin
                w_idx = w_count - W'(1);
                if (w_count == '0) n_status = plst_pkg::ST_UNDERFLOW;
                else w_rem = 1'b1;
            end
            plst_pkg::OP_REM_AT: begin
                w_idx = w_pos - W'(1);
                if (w_pos == '0 || w_pos > w_count) n_status = plst_pkg::ST_RANGE;
                else w_rem = 1'b1;
            end
            plst_pkg::OP_INS_BEFORE: begin
                w_idx = w_pos - W'(1);
                if (w_pos == '0 || w_pos > w_count + W'(1)) n_status = plst_pkg::ST_RANGE;
                else if (w_full) n_status = plst_pkg::ST_FULL;
                else w_ins = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_removed = '0;
        if (w_ins) n_count = r_count + CW'(1);
        if (w_rem) begin
            n_count   = r_count - CW'(1);
            n_removed = r_entries[w_sel];
        end
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        localparam logic [W-1:0] K = W'(k);
        logic [VALUE_BITS-1:0] w_prev;
        logic [VALUE_BITS-1:0] w_next;

        if (k > 0) begin : g_prev
            assign w_prev = r_entries[k-1];
        end else begin : g_prev0
            assign w_prev = r_entries[k];
        end
        if (k < CAPACITY - 1) begin : g_next
            assign w_next = r_entries[k+1];
        end else begin : g_next0
            assign w_next = r_entries[k];
        end

        always_comb begin
            n_entries[k] = r_entries[k];
            if (w_ins) begin
                if (K == w_idx) n_entries[k] = w_value;
                else if (K > w_idx && K <= w_count) n_entries[k] = w_prev;
            end else if (w_rem) begin
                if (K >= w_idx && K + W'(1) < w_count) n_entries[k] = w_next;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.load) r_entries[k] <= n_entries[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    assign o_status        = r_status;
    assign o_removed_value = 32'(r_removed);
    assign o_count         = 5'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        W'(r_count) <= CAP_W)
        else $error("entry count above capacity");
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && n_status == plst_pkg::ST_FULL) |=> (r_count == $past(r_count)))
        else $error("full request changed the count");
    a_error_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && n_status != plst_pkg::ST_OK) |=> (r_removed == '0))
        else $error("failed request returned a value");

endmodule

// ===== bench/positional_list_store_tb.sv =====
// Testbench for positional_list_store: directed boundary requests, then random traffic.
// Predicts each result from a local copy of the list and checks it in order.
// Depends on plst_pkg and the positional_list_store RTL.
`timescale 1ns / 1ps

module positional_list_store_tb;

    localparam int LIST_DEPTH     = 16;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] removed_value;
        logic [4:0]  count;
    } t_list_outcome;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_op = plst_pkg::OP_ADD_FRONT;
    logic [7:0]         i_position = 8'd0;
    logic signed [31:0] i_value = 32'sd0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_removed_value;
    logic [4:0]         o_count;

    logic [31:0]   list_vals [LIST_DEPTH];
    int            list_len = 0;
    t_list_outcome awaited_outcomes [$];
    int            mismatch_count = 0;
    int            send_gap_pct = 0;
    int            recv_stall_pct = 0;
    int            quiet_cycles = 0;
    bit            grow_mode = 1'b1;

    positional_list_store DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_count         (o_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_list_outcome apply_list_request(input logic [2:0] op,
                                                         input logic [7:0] pos,
                                                         input logic [31:0] val);
        t_list_outcome res;
        int            idx;
        res = '{status: plst_pkg::ST_OK, removed_value: 32'd0, count: 5'd0};
        idx = -1;
        case (op)
            plst_pkg::OP_ADD_FRONT, plst_pkg::OP_ADD_REAR: begin
                if (list_len >= LIST_DEPTH) res.status = plst_pkg::ST_FULL;
                else idx = (op == plst_pkg::OP_ADD_FRONT) ? 0 : list_len;
            end
            plst_pkg::OP_REM_FRONT, plst_pkg::OP_REM_REAR: begin
                if (list_len == 0) res.status = plst_pkg::ST_UNDERFLOW;
                else idx = (op == plst_pkg::OP_REM_FRONT) ? 0 : list_len - 1;
            end
            plst_pkg::OP_REM_AT: begin
                if (pos < 1 || pos > list_len) res.status = plst_pkg::ST_RANGE;
                else idx = pos - 1;
            end
            plst_pkg::OP_INS_BEFORE: begin
                if (pos < 1 || pos > list_len + 1) res.status = plst_pkg::ST_RANGE;
                else if (list_len >= LIST_DEPTH) res.status = plst_pkg::ST_FULL;
                else idx = pos - 1;
            end
            default: ;
        endcase
        if (idx >= 0) begin
            if (op == plst_pkg::OP_ADD_FRONT || op == plst_pkg::OP_ADD_REAR ||
                op == plst_pkg::OP_INS_BEFORE) begin
                for (int k = list_len; k > idx; k--) list_vals[k] = list_vals[k - 1];
                list_vals[idx] = val;
                list_len++;
            end else begin
                res.removed_value = list_vals[idx];
                for (int k = idx; k + 1 < list_len; k++) list_vals[k] = list_vals[k + 1];
                list_len--;
            end
        end
        res.count = list_len[4:0];
        return res;
    endfunction

    task automatic send_request(input logic [2:0] op, input logic [7:0] pos,
                                input logic [31:0] val);
        while ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_op       <= op;
        i_position <= pos;
        i_value    <= val;
        do @(posedge i_clk); while (o_stall);
        awaited_outcomes.push_back(apply_list_request(op, pos, val));
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_boundary_requests();
        send_gap_pct   = 21;
        recv_stall_pct = 79;
        send_request(plst_pkg::OP_REM_FRONT, 8'd0, 32'd0);
        send_request(plst_pkg::OP_REM_REAR, 8'd255, 32'hffff_ffff);
        send_request(plst_pkg::OP_REM_AT, 8'd0, 32'd0);
        send_request(plst_pkg::OP_REM_AT, 8'd1, 32'd0);
        send_request(plst_pkg::OP_INS_BEFORE, 8'd0, 32'h1234_5678);
        send_request(plst_pkg::OP_INS_BEFORE, 8'd2, 32'h1234_5678);
        send_request(plst_pkg::OP_INS_BEFORE, 8'd1, 32'h8000_0000);
        send_request(plst_pkg::OP_ADD_FRONT, 8'd0, 32'h7fff_ffff);
        send_request(plst_pkg::OP_ADD_REAR, 8'd255, 32'hffff_ffff);
        send_request(3'd6, 8'hff, 32'hffff_ffff);
        send_request(3'd7, 8'h00, 32'h0000_0000);
        send_request(plst_pkg::OP_INS_BEFORE, 8'd4, 32'h0000_0000);
        send_request(plst_pkg::OP_INS_BEFORE, 8'd2, 32'hdead_beef);
        send_request(plst_pkg::OP_REM_AT, 8'd5, 32'd0);
        send_request(plst_pkg::OP_REM_AT, 8'd6, 32'd0);
        send_request(plst_pkg::OP_REM_AT, 8'd255, 32'd0);
        send_request(plst_pkg::OP_INS_BEFORE, 8'd255, 32'h5555_aaaa);
        send_request(plst_pkg::OP_REM_AT, 8'd2, 32'd0);
        send_request(plst_pkg::OP_REM_FRONT, 8'd0, 32'd0);
        send_request(plst_pkg::OP_REM_REAR, 8'd0, 32'd0);
        send_request(plst_pkg::OP_REM_AT, 8'd1, 32'd0);
        send_request(plst_pkg::OP_REM_REAR, 8'd0, 32'd0);
    endtask

    task automatic test_random_traffic(input int n_requests, input int gap_pct,
                                       input int stall_pct);
        logic [2:0] op;
        logic [7:0] pos;
        int         limit;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        repeat (n_requests) begin
            if ($urandom_range(59) == 0) grow_mode = !grow_mode;
            if ($urandom_range(99) < 4) begin
                op = 3'd6 | 3'($urandom_range(1));
            end else if ($urandom_range(99) < (grow_mode ? 70 : 30)) begin
                case ($urandom_range(2))
                    0: op = plst_pkg::OP_ADD_FRONT;
                    1: op = plst_pkg::OP_ADD_REAR;
                    default: op = plst_pkg::OP_INS_BEFORE;
                endcase
            end else begin
                case ($urandom_range(2))
                    0: op = plst_pkg::OP_REM_FRONT;
                    1: op = plst_pkg::OP_REM_REAR;
                    default: op = plst_pkg::OP_REM_AT;
                endcase
            end
            limit = (op == plst_pkg::OP_INS_BEFORE) ? list_len + 1 : list_len;
            if (op != plst_pkg::OP_INS_BEFORE && op != plst_pkg::OP_REM_AT) begin
                pos = 8'($urandom_range(255));
            end else begin
                case ($urandom_range(19))
                    0: pos = 8'd0;
                    1: pos = 8'(limit + 1);
                    2: pos = 8'($urandom_range(255));
                    default: pos = 8'($urandom_range(limit > 1 ? limit : 1, 1));
                endcase
            end
            send_request(op, pos, pick_value());
        end
    endtask

    always @(posedge i_clk) begin
        t_list_outcome want;
        i_stall <= ($urandom_range(99) < recv_stall_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_outcomes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d removed %h count %0d",
                             o_status, o_removed_value, o_count);
            end else begin
                want = awaited_outcomes.pop_front();
                if (o_status !== want.status || o_removed_value !== want.removed_value ||
                    o_count !== want.count) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch at %0t: status %0d/%0d removed %h/%h count %0d/%0d",
                                 $realtime, want.status, o_status, want.removed_value,
                                 o_removed_value, want.count, o_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_boundary_requests();
        test_random_traffic(460, 21, 79);
        test_random_traffic(460, 79, 21);
        test_random_traffic(460, 0, 0);
        i_valid <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
